// File: design/rhr_pkg.sv
package rhr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int W = FRAC_BITS + 1;
  localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;
  localparam int NSEG = 64;

  // Knots and warped values in units of 1/10000.
  function automatic logic [13:0] knot(input logic [6:0] i);
    logic [13:0] t [0:64];
    t = '{14'd0,14'd156,14'd313,14'd469,14'd625,14'd781,14'd938,14'd1094,14'd1250,14'd1406,
          14'd1563,14'd1719,14'd1875,14'd2031,14'd2188,14'd2344,14'd2500,14'd2656,14'd2813,
          14'd2969,14'd3125,14'd3281,14'd3438,14'd3594,14'd3750,14'd3906,14'd4063,14'd4219,
          14'd4375,14'd4531,14'd4688,14'd4844,14'd5000,14'd5156,14'd5313,14'd5469,14'd5625,
          14'd5781,14'd5938,14'd6094,14'd6250,14'd6406,14'd6563,14'd6719,14'd6875,14'd7031,
          14'd7188,14'd7344,14'd7500,14'd7656,14'd7813,14'd7969,14'd8125,14'd8281,14'd8438,
          14'd8594,14'd8750,14'd8906,14'd9063,14'd9219,14'd9375,14'd9531,14'd9688,14'd9844,
          14'd10000};
    return (i > 7'd64) ? 14'd10000 : t[i];
  endfunction

  function automatic logic [13:0] warp(input logic [6:0] i);
    logic [13:0] t [0:64];
    t = '{14'd0,14'd52,14'd105,14'd160,14'd218,14'd277,14'd339,14'd404,14'd471,14'd542,
          14'd616,14'd693,14'd775,14'd862,14'd954,14'd1052,14'd1157,14'd1269,14'd1390,
          14'd1519,14'd1660,14'd1824,14'd1974,14'd2115,14'd2248,14'd2374,14'd2495,14'd2609,
          14'd2719,14'd2824,14'd2926,14'd3023,14'd3118,14'd3210,14'd3300,14'd3456,14'd3600,
          14'd3761,14'd3943,14'd4153,14'd4399,14'd4688,14'd5048,14'd5211,14'd5359,14'd5494,
          14'd5617,14'd5729,14'd5832,14'd5925,14'd6010,14'd6088,14'd6160,14'd6225,14'd6285,
          14'd6340,14'd6390,14'd6436,14'd6478,14'd6516,14'd6552,14'd6584,14'd6614,14'd6642,
          14'd6667};
    return (i > 7'd64) ? 14'd6667 : t[i];
  endfunction

  // Segment widths are 156 or 157; 6/(10000*dx) as a reciprocal scaled by 2^RS.
  localparam int RS = 50;
  localparam logic [40:0] RECIP156 = 41'(((64'd6 << RS) + 64'd1559999) / 64'd1560000);
  localparam logic [40:0] RECIP157 = 41'(((64'd6 << RS) + 64'd1569999) / 64'd1570000);

  typedef struct packed {
    logic [W-1:0] s;
    logic [W-1:0] v;
  } sv_t;

endpackage

// File: design/rhr_warp.sv
// Hue warp: segment search, interpolation numerator, reciprocal divide.
// Stages: s1 search, s2 numerator, s3/s4 split multiply, s5 correction.
module rhr_warp import rhr_pkg::*; (
  input  logic         clk,
  input  logic         adv,
  input  logic [W-1:0] h,
  output logic [W+2:0] hc
);

  logic [30:0] hs;
  logic [5:0]  j_nxt;
  logic [5:0]  j_r;
  logic [30:0] hs_r;
  logic [48:0] num_r;
  logic        d157_r, d157_q;
  logic [48:0] num_q;
  logic [89:0] plo_r, phi_r;
  logic [48:0] num_q2;
  logic        d157_q2;
  logic [90:0] prod_r;
  logic [W+3:0] q;
  logic [W+2:0] hc_r;
  logic [13:0] dx, dw;

  assign hs = 31'(h) * 31'd10000;

  always_comb begin
    j_nxt = '0;
    for (int i = 1; i < NSEG; i++) begin
      if ((31'(knot(7'(i))) << FRAC_BITS) <= hs) j_nxt = 6'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      j_r  <= j_nxt;
      hs_r <= hs;
    end
  end

  assign dx = knot({1'b0, j_r} + 7'd1) - knot({1'b0, j_r});
  assign dw = warp({1'b0, j_r} + 7'd1) - warp({1'b0, j_r});

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r   <= ((49'(warp({1'b0, j_r})) * 49'(dx)) << FRAC_BITS)
               + 49'(dw) * 49'(hs_r - (31'(knot({1'b0, j_r})) << FRAC_BITS));
      d157_r  <= (dx == 14'd157);
      num_q   <= num_r;
      d157_q  <= d157_r;
      // Split num*recip into two partial products.
      plo_r   <= 90'(num_r[24:0]) * 90'(d157_r ? RECIP157 : RECIP156);
      phi_r   <= 90'(num_r[48:25]) * 90'(d157_r ? RECIP157 : RECIP156);
      prod_r  <= 91'(plo_r) + (91'(phi_r) << 25);
      num_q2  <= num_q;
      d157_q2 <= d157_q;
      hc_r    <= q[W+2:0];
    end
  end

  // Reciprocal may overestimate by one: step back when q*D exceeds 6*num.
  always_comb begin
    q = (W+4)'(prod_r >> RS);
    if (64'(q) * 64'(d157_q2 ? 1570000 : 1560000) > 64'(num_q2) * 64'd6) q = q - (W+4)'(1);
  end

  assign hc = hc_r;

endmodule

// File: design/rainbow_hue_to_rgb.sv
// Perceptual-rainbow HSV to RGB in Q1.16. Fully pipelined: one word per
// cycle, unless a valid output is stalled, through seven register stages:
// the hue warp (table search, interpolation, two-stage reciprocal multiply,
// correction), then the sector select multiply and the brightness
// multiply. A stalled output holds the whole pipe and stalls the input.
module rainbow_hue_to_rgb import rhr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [W-1:0] in_hue,
  input  logic [W-1:0] in_saturation,
  input  logic [W-1:0] in_brightness,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [W-1:0] out_red,
  output logic [W-1:0] out_green,
  output logic [W-1:0] out_blue
);

  localparam int NST = 7;
  logic [NST-1:0] v_r;
  logic adv;
  sv_t sv_r [0:4];
  logic [W+2:0] hc;
  logic [W-1:0] hsat;
  logic [2:0] sec;
  logic [FRAC_BITS-1:0] f;
  logic [W-1:0] m_r, n_r, k_r, vv_r;
  logic [2:0] sec_r;
  logic [W-1:0] r, g, b;
  logic [W-1:0] red_r, green_r, blue_r;

  function automatic logic [W-1:0] sat(input logic [W-1:0] x);
    return (x > ONE) ? ONE : x;
  endfunction

  // Whole pipe holds while a valid output is stalled.
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  assign hsat = sat(in_hue);

  rhr_warp u_warp (.clk(clk), .adv(adv), .h(hsat), .hc(hc));

  always_ff @(posedge clk) begin
    if (adv) begin
      sv_r[0] <= '{s: sat(in_saturation), v: sat(in_brightness)};
      for (int i = 1; i < 5; i++) sv_r[i] <= sv_r[i-1];
    end
  end

  assign sec = (hc[W+2:FRAC_BITS] > 4'd5) ? 3'd5 : hc[FRAC_BITS+2:FRAC_BITS];
  assign f = hc[FRAC_BITS-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      sec_r <= sec;
      vv_r  <= sv_r[4].v;
      m_r   <= ONE - sv_r[4].s;
      n_r   <= ONE - W'((34'(sv_r[4].s) * 34'(f)) >> FRAC_BITS);
      k_r   <= ONE - W'((34'(sv_r[4].s) * 34'(ONE - W'(f))) >> FRAC_BITS);
    end
  end

  always_comb begin
    case (sec_r)
      3'd0: begin r = ONE; g = k_r; b = m_r; end
      3'd1: begin r = n_r; g = ONE; b = m_r; end
      3'd2: begin r = m_r; g = ONE; b = k_r; end
      3'd3: begin r = m_r; g = n_r; b = ONE; end
      3'd4: begin r = k_r; g = m_r; b = ONE; end
      default: begin r = ONE; g = m_r; b = n_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red_r   <= W'((34'(r) * 34'(vv_r)) >> FRAC_BITS);
      green_r <= W'((34'(g) * 34'(vv_r)) >> FRAC_BITS);
      blue_r  <= W'((34'(b) * 34'(vv_r)) >> FRAC_BITS);
    end
  end

  assign out_valid = v_r[NST-1];
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

// File: design/rhr_checker.sv
module rhr_checker import rhr_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  input logic         in_stall,
  input logic         out_valid,
  input logic         out_stall,
  input logic [W-1:0] out_red,
  input logic [W-1:0] out_green,
  input logic [W-1:0] out_blue
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red)) else $error("word dropped");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall)) else $error("stall mismatch");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_red <= ONE && out_green <= ONE && out_blue <= ONE) else $error("range");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid) else $error("reset");

endmodule

bind rainbow_hue_to_rgb rhr_checker u_chk (.*);

// File: verif/rainbow_hue_to_rgb_test.sv
module rainbow_hue_to_rgb_test;
  import rhr_pkg::*;

  typedef struct {
    logic [W-1:0] red;
    logic [W-1:0] green;
    logic [W-1:0] blue;
  } rgb_t;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_RANDOM = 1300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [W-1:0] in_hue = '0;
  logic [W-1:0] in_saturation = '0;
  logic [W-1:0] in_brightness = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [W-1:0] out_red, out_green, out_blue;

  int error_count = 0;
  int words_in = 0;
  int words_out = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;

  rainbow_hue_to_rgb dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report(input string what, input logic [W-1:0] got, input logic [W-1:0] want);
    $display("mismatch %s: got %0d expected %0d (word %0d)", what, got, want, words_out);
    error_count++;
  endtask

  // Warp table in units of 1/10000, kept separate from the package copy.
  int unsigned knots [0:64] = '{
    0, 156, 313, 469, 625, 781, 938, 1094, 1250, 1406,
    1563, 1719, 1875, 2031, 2188, 2344, 2500, 2656, 2813, 2969,
    3125, 3281, 3438, 3594, 3750, 3906, 4063, 4219, 4375, 4531,
    4688, 4844, 5000, 5156, 5313, 5469, 5625, 5781, 5938, 6094,
    6250, 6406, 6563, 6719, 6875, 7031, 7188, 7344, 7500, 7656,
    7813, 7969, 8125, 8281, 8438, 8594, 8750, 8906, 9063, 9219,
    9375, 9531, 9688, 9844, 10000};
  int unsigned warps [0:64] = '{
    0, 52, 105, 160, 218, 277, 339, 404, 471, 542,
    616, 693, 775, 862, 954, 1052, 1157, 1269, 1390, 1519,
    1660, 1824, 1974, 2115, 2248, 2374, 2495, 2609, 2719, 2824,
    2926, 3023, 3118, 3210, 3300, 3456, 3600, 3761, 3943, 4153,
    4399, 4688, 5048, 5211, 5359, 5494, 5617, 5729, 5832, 5925,
    6010, 6088, 6160, 6225, 6285, 6340, 6390, 6436, 6478, 6516,
    6552, 6584, 6614, 6642, 6667};

  function automatic longint unsigned clip_unit(logic [W-1:0] x);
    return (x > ONE) ? longint'(ONE) : longint'(x);
  endfunction

  function automatic rgb_t hsv_to_rgb(logic [W-1:0] hi, logic [W-1:0] si, logic [W-1:0] vi);
    longint unsigned one, h, s, v, hs, dx, dw, num, hc, sector, f, m, n, k, r, g, b;
    int j;
    rgb_t res;
    one = longint'(ONE);
    h = clip_unit(hi);
    s = clip_unit(si);
    v = clip_unit(vi);
    hs = h * 10000;
    j = 0;
    while (j < 63 && longint'(knots[j+1]) * one <= hs) j++;
    dx = knots[j+1] - knots[j];
    dw = warps[j+1] - warps[j];
    num = longint'(warps[j]) * dx * one + dw * (hs - longint'(knots[j]) * one);
    hc = (6 * num) / (10000 * dx);
    sector = hc >> FRAC_BITS;
    f = hc & (one - 1);
    m = one - s;
    n = one - ((s * f) >> FRAC_BITS);
    k = one - ((s * (one - f)) >> FRAC_BITS);
    if (sector > 5) sector = 5;
    case (sector)
      0: begin r = one; g = k; b = m; end
      1: begin r = n; g = one; b = m; end
      2: begin r = m; g = one; b = k; end
      3: begin r = m; g = n; b = one; end
      4: begin r = k; g = m; b = one; end
      default: begin r = one; g = m; b = n; end
    endcase
    res.red = W'((r * v) >> FRAC_BITS);
    res.green = W'((g * v) >> FRAC_BITS);
    res.blue = W'((b * v) >> FRAC_BITS);
    return res;
  endfunction

  class color_board;
    rgb_t pending[$];

    function void note_input(logic [W-1:0] h, logic [W-1:0] s, logic [W-1:0] v);
      pending.push_back(hsv_to_rgb(h, s, v));
    endfunction

    task check_result(logic [W-1:0] r, logic [W-1:0] g, logic [W-1:0] b);
      rgb_t want;
      if (pending.size() == 0) begin
        report("unexpected word", r, '0);
        return;
      end
      want = pending.pop_front();
      if (r !== want.red) report("red", r, want.red);
      if (g !== want.green) report("green", g, want.green);
      if (b !== want.blue) report("blue", b, want.blue);
    endtask
  endclass

  color_board board = new();

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        board.note_input(in_hue, in_saturation, in_brightness);
        words_in++;
      end
      if (out_valid && !out_stall) begin
        board.check_result(out_red, out_green, out_blue);
        words_out++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Receiver: stall for a random count after each word, sometimes not at all.
  initial begin : sink
    int wait_n;
    @(posedge clk iff rst_n);
    forever begin
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk iff out_valid);
    end
  end

  task automatic send_word(input logic [W-1:0] h, input logic [W-1:0] s, input logic [W-1:0] v,
                           input bit allow_gap);
    int gap;
    gap = allow_gap ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_hue <= h;
    in_saturation <= s;
    in_brightness <= v;
    @(posedge clk iff !in_stall);
  endtask

  function automatic logic [W-1:0] pick_field();
    case ($urandom_range(0, 9))
      0: return ONE;
      1: return '0;
      2: return W'($urandom_range(int'(ONE) + 1, (1 << W) - 1));
      3: return ONE - 1;
      default: return W'($urandom_range(0, int'(ONE)));
    endcase
  endfunction

  initial begin : stim
    logic [W-1:0] h;
    bit burst;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Field extremes, hue exactly one, inputs above one, knot boundaries.
    send_word('0, '0, '0, 1'b0);
    send_word(ONE, ONE, ONE, 1'b0);
    send_word(ONE, '0, ONE, 1'b0);
    send_word('1, '1, '1, 1'b0);
    send_word(ONE + 1, ONE, ONE, 1'b0);
    send_word('0, ONE, ONE, 1'b0);
    send_word(ONE - 1, ONE, ONE, 1'b1);
    send_word(W'(32768), ONE, ONE, 1'b1);
    send_word(W'(10224), ONE, ONE, 1'b0);
    send_word(W'(10223), ONE, ONE, 1'b0);
    send_word(W'(1), W'(1), W'(1), 1'b0);
    send_word(W'(21845), W'(43690), W'(65535), 1'b1);
    send_word(W'(43690), W'(21845), ONE, 1'b0);
    send_word(W'(54000), ONE, W'(30000), 1'b0);
    send_word(W'(6000), ONE, ONE, 1'b0);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      burst = ($urandom_range(0, 3) == 0);
      h = ($urandom_range(0, 4) == 0) ? pick_field() : W'($urandom_range(0, int'(ONE)));
      send_word(h, pick_field(), pick_field(), !burst);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin : finish_up
    wait (stim_done);
    @(posedge clk iff board.pending.size() == 0);
    repeat (20) @(posedge clk);
    $display("sent %0d hsv words, checked %0d rgb words", words_in, words_out);
    $display("covered hue extremes, saturated inputs and random gaps on both sides");
    if (error_count == 0 && board.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
